// ===== design/dang_pkg.sv =====
`default_nettype none

package dang_pkg;

	// Build-time configuration.
	localparam int CORDIC_STAGES = 24;
	localparam int FRAC_BITS     = 16;
	localparam int GUARD_SHIFT   = 24;

	// Field and datapath widths.
	localparam int IN_W    = 32;
	localparam int DIFF_W  = IN_W + 1;
	localparam int VEC_W   = DIFF_W + GUARD_SHIFT + 3;
	localparam int ANG_W   = FRAC_BITS + 11;
	localparam int SH_W    = $clog2(CORDIC_STAGES);
	localparam int QW      = 28;
	localparam int YAW_W   = 26;
	localparam int PITCH_W = 24;
	localparam int SIDE_W  = DIFF_W + 1;
	localparam int GAIN_W  = 32;
	localparam int HI_W    = VEC_W - GAIN_W;

	// Degrees per radian and the CORDIC gain compensation, both scaled by 2^32.
	localparam logic [63:0]       DEG_PER_RAD_Q32 = 64'd246083499208;
	localparam logic [GAIN_W-1:0] GAIN_COMP       = 32'h9B74EDA8;

	// Conversion of an accumulated angle to Q16.16.
	localparam int Q_SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int Q_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int Q_RND = (2 ** Q_SHR) / 2;

	localparam logic signed [QW-1:0] Q_P180 = QW'(180 * 65536);
	localparam logic signed [QW-1:0] Q_M180 = -Q_P180;
	localparam logic signed [QW-1:0] Q_P90  = QW'(90 * 65536);
	localparam logic signed [QW-1:0] Q_M90  = -Q_P90;

	localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(64'd180 << FRAC_BITS);

	typedef logic [SIDE_W-1:0] side_t;

	// One vector as it travels down a CORDIC chain, with the data that rides along.
	typedef struct packed {
		logic                    vld;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
		side_t                   side;
	} vec_t;

	typedef struct packed {
		logic signed [YAW_W-1:0]   yaw;
		logic signed [PITCH_W-1:0] pitch;
	} res_t;

	// atan(2^-idx) in degrees, from an arctangent series at 48 fraction bits,
	// rounded to 32, then half up to FRAC_BITS. Evaluated at elaboration only.
	function automatic logic signed [ANG_W-1:0] dang_step_angle(input int unsigned idx);
		logic [63:0] s48;
		logic [63:0] term;
		logic [63:0] a32;
		logic [63:0] sum;
		logic [63:0] rnd;
		int unsigned sh;
		s48 = DEG_PER_RAD_Q32 << 16;
		sum = '0;
		if (idx == 0) begin
			a32 = 64'd45 << 32;
		end else begin
			for (int unsigned k = 0; k < 64; k++) begin
				sh = idx * (2 * k + 1);
				if (sh < 63) begin
					term = (s48 >> sh) / 64'(2 * k + 1);
					if (k[0]) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
			end
			a32 = (sum + (64'd1 << 15)) >> 16;
		end
		rnd = (a32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
		return ANG_W'(rnd);
	endfunction

	// Accumulated angle to Q16.16, rounding half up.
	function automatic logic signed [QW-1:0] dang_to_q16(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W:0] t;
		t = (ANG_W + 1)'(a) + (ANG_W + 1)'(Q_RND);
		return QW'(t >>> Q_SHR) <<< Q_SHL;
	endfunction

endpackage

`default_nettype wire

// ===== design/direction_angles_3d.sv =====
// direction_angles_3d: yaw and pitch of the direction from an origin point to a target.
//
// Input channel (in_valid / in_ready): one transaction carries both points, each
// coordinate signed Q16.16. Output channel (out_valid / out_ready): one transaction
// per input with yaw_deg = atan2(dy,dx) + 90 and pitch_deg = elevation, both signed
// Q16.16 degrees. Yaw spans -90..270, pitch -90..90; a zero planar vector gives a
// yaw of 90, and a zero difference gives a pitch of 0.
//
// From acceptance to out_valid a transaction passes through one setup stage, a yaw
// pass of CORDIC_STAGES cells, two gain stages, a pitch pass of CORDIC_STAGES cells,
// one rounding stage and the output register. Throughput is one transaction per
// cycle while the receiver keeps up; every cell is a full pipeline stage.
//
// Reset (arst_n low) empties the pipeline and the output; in_ready comes up with it.
// When the receiver stalls, the next valid result lands in a spare entry behind the
// output register, in_ready drops and the whole pipeline holds in place. The held
// result moves up at the edge where out_ready returns, and the pipeline and in_ready
// resume as the spare entry empties at that same edge.
`default_nettype none

module direction_angles_3d (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [dang_pkg::IN_W-1:0]     from_x,
	input  logic signed [dang_pkg::IN_W-1:0]     from_y,
	input  logic signed [dang_pkg::IN_W-1:0]     from_z,
	input  logic signed [dang_pkg::IN_W-1:0]     to_x,
	input  logic signed [dang_pkg::IN_W-1:0]     to_y,
	input  logic signed [dang_pkg::IN_W-1:0]     to_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dang_pkg::YAW_W-1:0]    yaw_deg,
	output logic signed [dang_pkg::PITCH_W-1:0]  pitch_deg
);
	import dang_pkg::*;

	// Place a difference above the guard bits at full vector width.
	function automatic logic signed [VEC_W-1:0] guard(input logic signed [DIFF_W-1:0] d);
		return $signed({{(VEC_W - DIFF_W - GUARD_SHIFT){d[DIFF_W-1]}}, d,
			{GUARD_SHIFT{1'b0}}});
	endfunction

	logic adv;
	logic room;

	// The whole pipeline moves together whenever the spare output entry is free.
	assign adv      = room;
	assign in_ready = adv;

	// ---------------------------------------------------------------------------
	// Setup: differences at 33 bits, half-plane fold for negative dx.
	// ---------------------------------------------------------------------------
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic signed [DIFF_W-1:0] dz;
	logic signed [DIFF_W-1:0] ndx;
	logic signed [DIFF_W-1:0] ndy;
	logic                     dx_neg;
	logic                     planar_zero;

	always_comb begin
		dx          = DIFF_W'(to_x) - DIFF_W'(from_x);
		dy          = DIFF_W'(to_y) - DIFF_W'(from_y);
		dz          = DIFF_W'(to_z) - DIFF_W'(from_z);
		ndx         = DIFF_W'(from_x) - DIFF_W'(to_x);
		ndy         = DIFF_W'(from_y) - DIFF_W'(to_y);
		dx_neg      = dx[DIFF_W-1];
		planar_zero = (to_x == from_x) && (to_y == from_y);
	end

	logic                     vld_s1;
	logic signed [DIFF_W-1:0] px_s1;
	logic signed [DIFF_W-1:0] py_s1;
	logic signed [ANG_W-1:0]  ang_s1;
	logic signed [DIFF_W-1:0] dz_s1;
	logic                     pz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= dx_neg ? ndx : dx;
			py_s1 <= dx_neg ? ndy : dy;
			if (!dx_neg) begin
				ang_s1 <= '0;
			end else if (!dy[DIFF_W-1]) begin
				ang_s1 <= ANG_180;
			end else begin
				ang_s1 <= -ANG_180;
			end
			dz_s1 <= dz;
			pz_s1 <= planar_zero;
		end
	end

	// ---------------------------------------------------------------------------
	// Yaw pass: rotate (dx,dy) onto the x axis.
	// ---------------------------------------------------------------------------
	vec_t yaw_in;
	vec_t yaw_out;

	always_comb begin
		yaw_in.vld  = vld_s1;
		yaw_in.x    = guard(px_s1);
		yaw_in.y    = guard(py_s1);
		yaw_in.ang  = ang_s1;
		yaw_in.side = {pz_s1, dz_s1};
	end

	dang_pass u_pass_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.d_in   (yaw_in),
		.d_out  (yaw_out)
	);

	// ---------------------------------------------------------------------------
	// Gain compensation of the planar magnitude, as products of its high and low words
	// with the gain (60 and 64 bits wide). The yaw angle is rounded to Q16.16 alongside.
	// ---------------------------------------------------------------------------
	logic [VEC_W-1:0] mag;
	logic [HI_W-1:0]  mag_hi;
	logic [GAIN_W-1:0] mag_lo;

	always_comb begin
		mag    = (!yaw_out.x[VEC_W-1] && (|yaw_out.x)) ? VEC_W'(yaw_out.x) : '0;
		mag_hi = mag[VEC_W-1:GAIN_W];
		mag_lo = mag[GAIN_W-1:0];
	end

	logic                        vld_s2;
	logic [HI_W+GAIN_W-1:0]      prod_hi_s2;
	logic [2*GAIN_W-1:0]         prod_lo_s2;
	logic signed [QW-1:0]        yq_s2;
	logic signed [DIFF_W-1:0]    dz_s2;
	logic                        pz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= yaw_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_hi_s2 <= (HI_W + GAIN_W)'(mag_hi) * (HI_W + GAIN_W)'(GAIN_COMP);
			prod_lo_s2 <= (2 * GAIN_W)'(mag_lo) * (2 * GAIN_W)'(GAIN_COMP);
			yq_s2      <= dang_to_q16(yaw_out.ang);
			dz_s2      <= yaw_out.side[DIFF_W-1:0];
			pz_s2      <= yaw_out.side[DIFF_W];
		end
	end

	// Sum of the partial products, yaw clamp and offset. A zero planar vector
	// leaves the yaw pass at the origin, so its magnitude is already zero.
	logic [VEC_W-1:0]     r_sum;
	logic                 r_zero;
	logic signed [QW-1:0] yaw_clamp;
	logic signed [QW-1:0] yaw_fin;

	always_comb begin
		r_sum  = VEC_W'(prod_hi_s2) + VEC_W'(prod_lo_s2[2*GAIN_W-1:GAIN_W]);
		r_zero = (prod_hi_s2 == '0) && (prod_lo_s2[2*GAIN_W-1:GAIN_W] == '0);
		if (yq_s2 < Q_M180) begin
			yaw_clamp = Q_M180;
		end else if (yq_s2 > Q_P180) begin
			yaw_clamp = Q_P180;
		end else begin
			yaw_clamp = yq_s2;
		end
		yaw_fin = pz_s2 ? Q_P90 : yaw_clamp + Q_P90;
	end

	logic                     vld_s3;
	logic signed [VEC_W-1:0]  r_s3;
	logic signed [DIFF_W-1:0] dz_s3;
	logic signed [YAW_W-1:0]  yaw_s3;
	logic                     vz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s3   <= $signed(r_sum);
			dz_s3  <= dz_s2;
			yaw_s3 <= YAW_W'(yaw_fin);
			vz_s3  <= r_zero && (dz_s2 == '0);
		end
	end

	// ---------------------------------------------------------------------------
	// Pitch pass: rotate (magnitude, dz) onto the x axis.
	// ---------------------------------------------------------------------------
	vec_t pit_in;
	vec_t pit_out;

	always_comb begin
		pit_in.vld  = vld_s3;
		pit_in.x    = r_s3;
		pit_in.y    = guard(dz_s3);
		pit_in.ang  = '0;
		pit_in.side = {{(SIDE_W - YAW_W - 1){1'b0}}, vz_s3, yaw_s3};
	end

	dang_pass u_pass_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.d_in   (pit_in),
		.d_out  (pit_out)
	);

	// ---------------------------------------------------------------------------
	// Pitch rounding, then clamp on the way into the output register.
	// ---------------------------------------------------------------------------
	logic                    vld_s4;
	logic signed [QW-1:0]    pq_s4;
	logic signed [YAW_W-1:0] yaw_s4;
	logic                    vz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= pit_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pq_s4  <= dang_to_q16(pit_out.ang);
			yaw_s4 <= pit_out.side[YAW_W-1:0];
			vz_s4  <= pit_out.side[YAW_W];
		end
	end

	logic signed [QW-1:0] pitch_clamp;
	res_t                 res;
	res_t                 res_out;
	logic                 push;

	always_comb begin
		if (vz_s4) begin
			pitch_clamp = '0;
		end else if (pq_s4 < Q_M90) begin
			pitch_clamp = Q_M90;
		end else if (pq_s4 > Q_P90) begin
			pitch_clamp = Q_P90;
		end else begin
			pitch_clamp = pq_s4;
		end
		res.yaw   = yaw_s4;
		res.pitch = PITCH_W'(pitch_clamp);
		push      = vld_s4 && adv;
	end

	dang_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.d_in      (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.d_out     (res_out)
	);

	assign yaw_deg   = res_out.yaw;
	assign pitch_deg = res_out.pitch;

`ifndef ASSERT_OFF
	// The spare entry only fills behind a held output register.
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low without a result at the output");

	// Backpressure appears only after the receiver refused a result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without a stalled output");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_deg >= -26'sd5898240) && (yaw_deg <= 26'sd17694720))
		else $error("yaw_deg outside -90..270 degrees");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_deg >= -24'sd5898240) && (pitch_deg <= 24'sd5898240))
		else $error("pitch_deg outside -90..90 degrees");
`endif

endmodule

`default_nettype wire

// ===== design/dang_cell.sv =====
`default_nettype none

module dang_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic [dang_pkg::SH_W-1:0]         shift,
	input  logic signed [dang_pkg::ANG_W-1:0] step_ang,
	input  dang_pkg::vec_t                    d_in,
	output dang_pkg::vec_t                    d_out
);
	import dang_pkg::*;

	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] ys;
	logic signed [VEC_W-1:0] x_nx;
	logic signed [VEC_W-1:0] y_nx;
	logic signed [ANG_W-1:0] ang_nx;

	logic                    vld_q;
	logic signed [VEC_W-1:0] x_q;
	logic signed [VEC_W-1:0] y_q;
	logic signed [ANG_W-1:0] ang_q;
	side_t                   side_q;

	// One micro-rotation: turn toward the x axis by atan(2^-shift).
	always_comb begin
		xs = $signed(d_in.x) >>> shift;
		ys = $signed(d_in.y) >>> shift;
		if (!d_in.y[VEC_W-1]) begin
			x_nx   = $signed(d_in.x) + ys;
			y_nx   = $signed(d_in.y) - xs;
			ang_nx = $signed(d_in.ang) + step_ang;
		end else begin
			x_nx   = $signed(d_in.x) - ys;
			y_nx   = $signed(d_in.y) + xs;
			ang_nx = $signed(d_in.ang) - step_ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			ang_q  <= ang_nx;
			side_q <= d_in.side;
		end
	end

	always_comb begin
		d_out.vld  = vld_q;
		d_out.x    = x_q;
		d_out.y    = y_q;
		d_out.ang  = ang_q;
		d_out.side = side_q;
	end

endmodule

`default_nettype wire

// ===== design/dang_pass.sv =====
`default_nettype none

module dang_pass (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  dang_pkg::vec_t d_in,
	output dang_pkg::vec_t d_out
);
	import dang_pkg::*;

	vec_t lnk [CORDIC_STAGES+1];

	assign lnk[0] = d_in;

	// A full vectoring pass: one cell per iteration, each with a fixed shift and angle.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ANG_W-1:0] StepAng = dang_step_angle(i);

		dang_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.shift    (SH_W'(i)),
			.step_ang (StepAng),
			.d_in     (lnk[i]),
			.d_out    (lnk[i+1])
		);
	end

	assign d_out = lnk[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== design/dang_skid.sv =====
`default_nettype none

module dang_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dang_pkg::res_t d_in,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output dang_pkg::res_t d_out
);
	import dang_pkg::*;

	logic out_vld_q;
	logic skd_vld_q;
	res_t out_q;
	res_t skd_q;
	logic take;
	logic load_out;

	assign take     = out_vld_q && out_ready;
	assign load_out = !out_vld_q || take;

	// The spare entry catches the one result that arrives while the output is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= skd_vld_q || push;
			skd_vld_q <= 1'b0;
		end else if (push) begin
			skd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skd_vld_q ? skd_q : d_in;
		end
		if (!load_out && push) begin
			skd_q <= d_in;
		end
	end

	assign room      = !skd_vld_q;
	assign out_valid = out_vld_q;
	assign d_out     = out_q;

endmodule

`default_nettype wire
